// ----- hdl/dsc_pkg.sv -----
// ----------------------------------------------------------------------------
// dsc_pkg
// shared widths, command codes and sequencer states for the divisible
// subarray counter
// ----------------------------------------------------------------------------
package dsc_pkg;

   localparam int CFG_W               = 11;
   localparam int VALUE_W             = 32;
   localparam int SUM_W               = VALUE_W + 2;
   localparam int TOTAL_W             = 48;
   localparam int COUNT_W             = 32;
   localparam int DIV_STEPS           = VALUE_W;
   localparam int STEP_W              = $clog2(DIV_STEPS);
   localparam int DEFAULT_MAX_MODULUS = 1024;

   typedef enum logic {
      CMD_ADD   = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_FIX,
      ST_READ,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

// ----- hdl/divisible_subarray_counter_top.sv -----
// element transfer: 32 remainder steps of the shared restoring subtractor,
// then sign fix, histogram read and update, before the result is offered
// busy: no new item is taken until the current result has been offered
// clear command: one histogram entry swept per cycle, then a result
// reset: synchronous; modulus returns to one, then a clearing pass over
// the histogram runs while req_stall stays high
// ----------------------------------------------------------------------------
// divisible_subarray_counter_top
// counts subarrays of a signed stream whose sum is divisible by a modulus,
// using a prefix residue and a residue histogram held in a memory
// ----------------------------------------------------------------------------
module divisible_subarray_counter_top #(
   parameter int MAX_MODULUS = dsc_pkg::DEFAULT_MAX_MODULUS,
   parameter int RES_W       = $clog2(MAX_MODULUS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dsc_pkg::CFG_W-1:0]     csr_modulus,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic signed [dsc_pkg::VALUE_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dsc_pkg::TOTAL_W-1:0]   rsp_total_count,
   output logic [RES_W-1:0]              rsp_residue
);
   import dsc_pkg::*;

   localparam logic [RES_W-1:0] LAST_IDX = RES_W'(MAX_MODULUS - 1);

   logic [COUNT_W-1:0] hist_mem [MAX_MODULUS];

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   modulus_ff, modulus_in;
   logic [CFG_W-1:0]   em_ff, em_in;
   logic               neg_ff, neg_in;
   logic [VALUE_W-1:0] dividend_ff, dividend_in;
   logic [CFG_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [RES_W-1:0]   prefix_ff, prefix_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [RES_W-1:0]   clr_idx_ff, clr_idx_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [COUNT_W-1:0] rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic [RES_W-1:0]   rsp_residue_ff, rsp_residue_in;

   logic               mem_we;
   logic [RES_W-1:0]   mem_waddr;
   logic [COUNT_W-1:0] mem_wdata;

   logic [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]   mag;
   logic [CFG_W:0]     trial;
   logic [CFG_W-1:0]   fixed;
   logic [TOTAL_W:0]   total_sum;
   logic [CFG_W-1:0]   em_cur;

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_total_count = rsp_total_ff;
   assign rsp_residue     = rsp_residue_ff;

   always_comb begin
      if (modulus_ff == '0) begin
         em_cur = CFG_W'(1);
      end else if (32'(modulus_ff) > 32'(MAX_MODULUS)) begin
         em_cur = CFG_W'(MAX_MODULUS);
      end else begin
         em_cur = modulus_ff;
      end
   end

   assign sum = SUM_W'({{(SUM_W - RES_W){1'b0}}, prefix_ff})
              + {{(SUM_W - VALUE_W){req_value[VALUE_W-1]}}, req_value};
   assign mag = sum[SUM_W-1] ? SUM_W'(~sum + SUM_W'(1)) : sum;

   assign trial = {rem_ff, dividend_ff[VALUE_W-1]};
   assign fixed = (neg_ff && rem_ff != '0) ? CFG_W'(em_ff - rem_ff) : rem_ff;
   assign total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(rd_data_ff);

   always_comb begin
      state_in       = state_ff;
      modulus_in     = (csr_valid && csr_ready) ? csr_modulus : modulus_ff;
      em_in          = em_ff;
      neg_in         = neg_ff;
      dividend_in    = dividend_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      prefix_in      = prefix_ff;
      total_in       = total_ff;
      clr_idx_in     = clr_idx_ff;
      clr_rsp_in     = clr_rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_total_in   = rsp_total_ff;
      rsp_residue_in = rsp_residue_ff;
      req_stall      = 1'b1;
      mem_we         = 1'b0;
      mem_waddr      = prefix_ff;
      mem_wdata      = rd_data_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_ff;
            mem_wdata = (clr_idx_ff == '0) ? COUNT_W'(1) : '0;
            if (clr_idx_ff == LAST_IDX) begin
               clr_rsp_in = 1'b0;
               state_in   = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + RES_W'(1);
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (cmd_type'(req_command) == CMD_CLEAR) begin
                  prefix_in  = '0;
                  total_in   = '0;
                  clr_idx_in = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = ST_CLEAR;
               end else begin
                  em_in       = em_cur;
                  neg_in      = sum[SUM_W-1];
                  dividend_in = mag[VALUE_W-1:0];
                  rem_in      = '0;
                  step_in     = STEP_W'(DIV_STEPS - 1);
                  state_in    = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            dividend_in = {dividend_ff[VALUE_W-2:0], 1'b0};
            if (trial >= {1'b0, em_ff}) begin
               rem_in = CFG_W'(trial - {1'b0, em_ff});
            end else begin
               rem_in = trial[CFG_W-1:0];
            end
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            prefix_in = RES_W'(fixed);
            state_in  = ST_READ;
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            total_in  = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            mem_we    = (rd_data_ff != '1);
            mem_wdata = rd_data_ff + COUNT_W'(1);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_total_in   = total_ff;
               rsp_residue_in = prefix_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         modulus_ff   <= CFG_W'(1);
         prefix_ff    <= '0;
         total_ff     <= '0;
         clr_idx_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         prefix_ff    <= prefix_in;
         total_ff     <= total_in;
         clr_idx_ff   <= clr_idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      em_ff          <= em_in;
      neg_ff         <= neg_in;
      dividend_ff    <= dividend_in;
      rem_ff         <= rem_in;
      step_ff        <= step_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_residue_ff <= rsp_residue_in;
   end

   // histogram memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= hist_mem[prefix_ff];
   end

endmodule

// ----- hdl/dsc_checker.sv -----
// ----------------------------------------------------------------------------
// dsc_checker
// port level checks for the divisible subarray counter, bound to the top
// ----------------------------------------------------------------------------
module dsc_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [dsc_pkg::TOTAL_W-1:0] rsp_total_count
);
   import dsc_pkg::*;

   // no result valid right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // one item at a time: busy right after an input transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is in work");

   // a new result only comes out of a busy period
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_total_count))
      else $error("stalled result changed");

endmodule

bind divisible_subarray_counter_top dsc_checker u_dsc_checker (.*);

// ----- tb/tb_divisible_subarray_counter_top.sv -----
// ----------------------------------------------------------------------------
// tb_divisible_subarray_counter_top
// self-checking bench for the divisible subarray counter: a shadow of the
// prefix residue, residue histogram and running total predicts every result,
// which is compared field by field as it leaves the block. directed checks of
// value extremes, clear, modulus edges and a mid-sequence modulus change come
// first, then a long receiver hold-off, then randomized clear-led sequences
// over a range of modulus settings, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_divisible_subarray_counter_top;
   import dsc_pkg::*;

   localparam int MAX_MOD = DEFAULT_MAX_MODULUS;
   localparam int RES_W   = $clog2(MAX_MOD);
   localparam logic [TOTAL_W-1:0] TOTAL_LIMIT = '1;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [RES_W-1:0]   residue;
   } prefix_result_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CFG_W-1:0]           csr_modulus;
   logic                       req_valid;
   logic                       req_stall;
   cmd_type                    req_command;
   logic signed [VALUE_W-1:0]  req_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [TOTAL_W-1:0]         rsp_total_count;
   logic [RES_W-1:0]           rsp_residue;

   logic [COUNT_W-1:0] shadow_hist [MAX_MOD];
   logic [RES_W-1:0]   shadow_residue;
   logic [TOTAL_W-1:0] shadow_total;
   logic [CFG_W-1:0]   shadow_modulus;
   prefix_result_type  pending_counts [$];

   bit          no_idle       = 1'b0;
   int unsigned rsp_hold_len  = 0;
   int unsigned mismatches    = 0;
   int unsigned results_seen  = 0;
   int unsigned elements_sent = 0;
   int unsigned clears_sent   = 0;
   int unsigned csr_writes    = 0;

   divisible_subarray_counter_top #(
      .MAX_MODULUS (MAX_MOD)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_modulus     (csr_modulus),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_total_count (rsp_total_count),
      .rsp_residue     (rsp_residue)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #32_000_000;
      $display("divisible_subarray_counter_top verification failed");
      $finish;
   end

   function automatic void reset_shadow_sequence();
      foreach (shadow_hist[i]) shadow_hist[i] = '0;
      shadow_hist[0] = 1;
      shadow_residue = '0;
      shadow_total   = '0;
   endfunction

   function automatic void predict_count_step(input cmd_type cmd,
                                              input logic signed [VALUE_W-1:0] value);
      longint             eff;
      longint             rem;
      logic [COUNT_W-1:0] cnt;
      logic [TOTAL_W:0]   grown;
      prefix_result_type  res;
      if (cmd == CMD_CLEAR) begin
         reset_shadow_sequence();
      end else begin
         eff = (shadow_modulus == 0) ? 1 : longint'(shadow_modulus);
         if (eff > MAX_MOD) eff = MAX_MOD;
         rem = (longint'(shadow_residue) + longint'(value)) % eff;
         if (rem < 0) rem += eff;
         shadow_residue = rem[RES_W-1:0];
         cnt = shadow_hist[shadow_residue];
         grown = shadow_total + cnt;
         shadow_total = grown[TOTAL_W] ? TOTAL_LIMIT : grown[TOTAL_W-1:0];
         if (cnt != COUNT_LIMIT) shadow_hist[shadow_residue] = cnt + 1'b1;
      end
      res.total   = shadow_total;
      res.residue = shadow_residue;
      pending_counts.push_back(res);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom_range(0, 64) - 32;
         4: return (int'($urandom_range(0, 16)) - 8) * int'(shadow_modulus);
         5, 6: return $urandom();
         7: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return '1;
               default: return '0;
            endcase
         end
         8: return $urandom() >> $urandom_range(0, 31);
         default: return -($urandom() >> $urandom_range(0, 31));
      endcase
   endfunction

   task automatic send_item(input cmd_type cmd, input logic signed [VALUE_W-1:0] value);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_count_step(cmd, value);
      if (cmd == CMD_CLEAR) clears_sent++;
      else elements_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_counts.size() != 0);
   endtask

   task automatic write_modulus(input logic [CFG_W-1:0] modulus);
      wait_drain();
      csr_valid   <= 1'b1;
      csr_modulus <= modulus;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      shadow_modulus = modulus;
      csr_writes++;
   endtask

   // modulus still at its reset value of one
   task automatic test_reset_modulus();
      send_item(CMD_ADD, 5);
      send_item(CMD_ADD, -7);
      send_item(CMD_ADD, 123456);
      send_item(CMD_CLEAR, 32'hdead_beef);
   endtask

   task automatic test_value_extremes();
      write_modulus(11'd1024);
      send_item(CMD_ADD, 32'h7fff_ffff);
      send_item(CMD_ADD, 32'h8000_0000);
      send_item(CMD_ADD, -1);
      send_item(CMD_ADD, 0);
      send_item(CMD_ADD, 1);
      send_item(CMD_ADD, 1023);
      send_item(CMD_ADD, -1024);
      send_item(CMD_CLEAR, 32'h8000_0000);
   endtask

   task automatic test_modulus_edges();
      write_modulus(11'd0);
      send_item(CMD_ADD, 32'h7fff_ffff);
      send_item(CMD_ADD, -3);
      write_modulus(11'd2047);
      send_item(CMD_ADD, -1);
      send_item(CMD_ADD, 1024);
      send_item(CMD_ADD, 5);
      // new modulus without a clear: old residue and counts carry over
      write_modulus(11'd7);
      send_item(CMD_ADD, 3);
      send_item(CMD_ADD, 14);
      send_item(CMD_ADD, -1000);
   endtask

   task automatic test_receiver_holdoff();
      send_item(CMD_CLEAR, '0);
      wait_drain();
      rsp_hold_len = 400;
      no_idle = 1'b1;
      repeat (20) send_item(CMD_ADD, pick_value());
      no_idle = 1'b0;
      wait_drain();
   endtask

   task automatic test_random_sequences();
      logic [CFG_W-1:0] modulus_plan [8];
      int unsigned      phase_items;
      int unsigned      seq_len;
      modulus_plan = '{11'd1, 11'd0, 11'd1024, 11'd2047, 11'd2, 11'd37,
                       11'($urandom_range(3, 1023)), 11'($urandom_range(1025, 2046))};
      foreach (modulus_plan[p]) begin
         write_modulus(modulus_plan[p]);
         phase_items = 0;
         while (phase_items < 95) begin
            no_idle = (p == 4) || ($urandom_range(0, 5) == 0);
            // most sequences start from a clear, a few run on from the old state
            if ($urandom_range(0, 7) != 0) begin
               send_item(CMD_CLEAR, $urandom());
               phase_items++;
            end
            seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 25);
            repeat (seq_len) begin
               if ($urandom_range(0, 49) == 0) wait_drain();
               send_item(CMD_ADD, pick_value());
               phase_items++;
            end
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin : result_sink
      int unsigned pause;
      pause = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len != 0) begin
            pause = rsp_hold_len;
            rsp_hold_len = 0;
         end else if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            pause = no_idle ? 0 : $urandom_range(0, 4);
         end else if (pause != 0) begin
            pause--;
         end
         rsp_stall <= (pause != 0);
      end
   end

   always @(posedge clock) begin : result_check
      prefix_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         if (pending_counts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: total %0d residue %0d",
                        rsp_total_count, rsp_residue);
         end else begin
            want = pending_counts.pop_front();
            if (rsp_total_count !== want.total || rsp_residue !== want.residue) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected total %0d residue %0d, got total %0d residue %0d",
                           results_seen, want.total, want.residue,
                           rsp_total_count, rsp_residue);
            end
         end
      end
   end

   initial begin
      csr_valid   = 1'b0;
      csr_modulus = '0;
      req_valid   = 1'b0;
      req_command = CMD_ADD;
      req_value   = '0;
      reset       = 1'b1;
      reset_shadow_sequence();
      shadow_modulus = 11'd1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_modulus();
      test_value_extremes();
      test_modulus_edges();
      test_receiver_holdoff();
      test_random_sequences();

      wait_drain();
      repeat (60) @(posedge clock);

      $display("covered %0d element and %0d clear transfers across %0d modulus writes",
               elements_sent, clears_sent, csr_writes);
      $display("%0d results compared, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0 && pending_counts.size() == 0) begin
         $display("divisible_subarray_counter_top verification clean");
      end else begin
         $display("divisible_subarray_counter_top verification failed");
      end
      $finish;
   end

endmodule
